@@ design/wco_pkg.sv @@
// Shared types and constants of the wavetable crossfade oscillator.
package wco_pkg;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_SET  = 2'd2;

  localparam logic [2:0] SET_PHASE = 3'd0;
  localparam logic [2:0] SET_STEP  = 3'd1;
  localparam logic [2:0] SET_FADE1 = 3'd2;
  localparam logic [2:0] SET_FADE2 = 3'd3;
  localparam logic [2:0] SET_FADE3 = 3'd4;

  localparam logic [2:0] CFG_MODE       = 3'd0;
  localparam logic [2:0] CFG_FREQ_STEP  = 3'd1;
  localparam logic [2:0] CFG_FADE1_STEP = 3'd2;
  localparam logic [2:0] CFG_FADE2_STEP = 3'd3;
  localparam logic [2:0] CFG_FADE3_STEP = 3'd4;

  localparam logic signed [31:0] FADE_UNITY = 32'sh1000_0000;
  localparam int unsigned FadeFracW = 28;

  typedef struct packed {
    logic       load_word;
    logic       set_value;
    logic       rd_en;
    logic       rd_next;
    logic [2:0] tbl;
    logic       latch_a;
    logic       mul_interp;
    logic       mul_fade;
    logic       push_interp;
    logic       push_fade;
    logic [1:0] dim;
    logic       update;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       out_free;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
    logic signed [15:0] r;
    if (x > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (x < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

@@ design/wavetable_crossfade_oscillator.sv @@
// Top level of the wavetable crossfade oscillator.
// The slave stream carries commands: tuser gives the kind and the table or
// value selector, tdata the entry index and the 32-bit value. A load
// transaction writes one saturated word into one of eight wave tables, a set
// transaction writes the phase, the phase step or a fade level, and a tick
// transaction produces one sample on the master stream.
// Load and set transactions are taken only while no tick is in progress.
// A tick reads each selected table in turn (two wave store reads, a multiply
// and an add), then runs any crossfades (a multiply and an add each), then
// the update and the output; the single shared multiplier and the single
// read port of the wave store make these steps run one after another.
// Registers are to be written through the configuration port only while no
// tick is in progress; the block does not enforce this. Reset clears the
// running state, the registers and the output flag; the wave tables hold
// nothing defined until loaded. If the receiver stalls, the finished sample
// waits in the output register; the next tick halts once its sample is ready.
module wavetable_crossfade_oscillator #(
  parameter int unsigned LOG2_WAVE_SIZE = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // table_index [9:0], value [41:10], zeros above
  input  logic [4:0]  s_axis_tuser,   // kind [1:0], table_select [4:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // sample [15:0]
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  wco_pkg::cmd_t      cmd;
  wco_pkg::status_t   status;
  logic signed [15:0] sample;

  wco_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser[1:0]),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wco_datapath #(
    .LOG2_WAVE_SIZE(LOG2_WAVE_SIZE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .in_sel_i     (s_axis_tuser[4:2]),
    .in_index_i   (s_axis_tdata[9:0]),
    .in_value_i   (s_axis_tdata[41:10]),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (sample)
  );

  assign m_axis_tdata = sample;

endmodule

@@ design/wco_ctrl.sv @@
// Sequencer that steps the datapath through interpolation, crossfades and state update.
module wco_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_kind_i,
  input  wco_pkg::status_t   status_i,
  output wco_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_I_MUL, S_I_ACC, S_F_MUL, S_F_ACC, S_UPDATE, S_DONE
  } state_e;

  state_e     state_q;
  logic [2:0] t_q;
  logic [1:0] dim_q;
  logic [1:0] fcnt_q;
  logic       last_t;
  logic [1:0] last_f;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_t     = (t_q == ((3'd1 << status_i.mode) - 3'd1));

  always_comb begin
    unique case (dim_q)
      2'd3:    last_f = 2'd3;
      2'd2:    last_f = 2'd1;
      default: last_f = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      t_q     <= '0;
      dim_q   <= '0;
      fcnt_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && in_kind_i == wco_pkg::KIND_TICK) begin
            t_q     <= '0;
            state_q <= S_RD_A;
          end
        end
        S_RD_A:  state_q <= S_RD_B;
        S_RD_B:  state_q <= S_I_MUL;
        S_I_MUL: state_q <= S_I_ACC;
        S_I_ACC: begin
          if (!last_t) begin
            t_q     <= t_q + 3'd1;
            state_q <= S_RD_A;
          end else if (status_i.mode == 2'd0) begin
            state_q <= S_UPDATE;
          end else begin
            dim_q   <= status_i.mode;
            fcnt_q  <= '0;
            state_q <= S_F_MUL;
          end
        end
        S_F_MUL: state_q <= S_F_ACC;
        S_F_ACC: begin
          if (fcnt_q != last_f) begin
            fcnt_q  <= fcnt_q + 2'd1;
            state_q <= S_F_MUL;
          end else if (dim_q == 2'd1) begin
            state_q <= S_UPDATE;
          end else begin
            dim_q   <= dim_q - 2'd1;
            fcnt_q  <= '0;
            state_q <= S_F_MUL;
          end
        end
        S_UPDATE: state_q <= S_DONE;
        S_DONE: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.tbl       = t_q;
    cmd_o.dim       = dim_q;
    cmd_o.load_word = accept && (in_kind_i == wco_pkg::KIND_LOAD);
    cmd_o.set_value = accept && (in_kind_i == wco_pkg::KIND_SET);
    cmd_o.rd_en     = (state_q == S_RD_A) || (state_q == S_RD_B);
    cmd_o.rd_next   = (state_q == S_RD_B);
    cmd_o.latch_a   = (state_q == S_RD_B);
    cmd_o.mul_interp  = (state_q == S_I_MUL);
    cmd_o.push_interp = (state_q == S_I_ACC);
    cmd_o.mul_fade    = (state_q == S_F_MUL);
    cmd_o.push_fade   = (state_q == S_F_ACC);
    cmd_o.update      = (state_q == S_UPDATE);
    cmd_o.out_load    = (state_q == S_DONE) && status_i.out_free;
  end

endmodule

@@ design/wco_datapath.sv @@
// Wave store, shared multiplier, crossfade shift line, running state and output register.
module wco_datapath #(
  parameter int unsigned LOG2_WAVE_SIZE = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wco_pkg::cmd_t       cmd_i,
  output wco_pkg::status_t    status_o,
  input  logic [2:0]          in_sel_i,
  input  logic [9:0]          in_index_i,
  input  logic signed [31:0]  in_value_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  out_sample_o
);

  localparam int unsigned FracW  = 32 - LOG2_WAVE_SIZE;
  localparam int unsigned AddrW  = 3 + LOG2_WAVE_SIZE;
  localparam int unsigned Depth  = 8 << LOG2_WAVE_SIZE;

  logic signed [15:0] mem [Depth];
  logic signed [15:0] rdata_q;
  logic signed [15:0] a_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] w_q [8];

  logic [1:0]         mode_q;
  logic signed [31:0] freq_step_q, f1_step_q, f2_step_q, f3_step_q;
  logic [31:0]        phase_q, step_q;
  logic signed [31:0] f1_q, f2_q, f3_q;
  logic               frozen_q;
  logic               out_valid_q;
  logic signed [15:0] sample_q;

  logic [LOG2_WAVE_SIZE-1:0] idx0, idx1, widx;
  logic [AddrW-1:0]          raddr, waddr;
  logic signed [31:0]        frac;
  logic signed [16:0]        diff_ab;
  logic signed [31:0]        mul_a, mul_b;
  logic signed [31:0]        w_lo, w_hi, fade_sel;
  logic signed [63:0]        prod_sh;
  logic signed [31:0]        push_val;
  logic signed [31:0]        f1_sum, f1_next;

  assign idx0  = phase_q[31 -: LOG2_WAVE_SIZE];
  assign idx1  = idx0 + (LOG2_WAVE_SIZE)'(1);
  assign frac  = $signed({{LOG2_WAVE_SIZE{1'b0}}, phase_q[FracW-1:0]});
  assign raddr = {cmd_i.tbl, cmd_i.rd_next ? idx1 : idx0};
  assign widx  = (LOG2_WAVE_SIZE)'(in_index_i);
  assign waddr = {in_sel_i, widx};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word) begin
      mem[waddr] <= wco_pkg::sat16(in_value_i);
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_comb begin
    unique case (cmd_i.dim)
      2'd3: begin
        w_lo = w_q[0]; w_hi = w_q[4]; fade_sel = f3_q;
      end
      2'd2: begin
        w_lo = w_q[4]; w_hi = w_q[6]; fade_sel = f2_q;
      end
      default: begin
        w_lo = w_q[6]; w_hi = w_q[7]; fade_sel = f1_q;
      end
    endcase
  end

  assign diff_ab = {rdata_q[15], rdata_q} - {a_q[15], a_q};
  assign mul_a   = cmd_i.mul_fade ? (w_hi - w_lo) : 32'(diff_ab);
  assign mul_b   = cmd_i.mul_fade ? fade_sel : frac;
  assign prod_sh = cmd_i.push_fade ? (prod_q >>> wco_pkg::FadeFracW) : (prod_q >>> FracW);
  assign push_val = (cmd_i.push_fade ? w_lo : 32'(a_q)) + prod_sh[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_a) begin
      a_q <= rdata_q;
    end
    if (cmd_i.mul_interp || cmd_i.mul_fade) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.push_interp || cmd_i.push_fade) begin
      for (int k = 0; k < 7; k++) begin
        w_q[k] <= w_q[k+1];
      end
      w_q[7] <= push_val;
    end
    if (cmd_i.out_load) begin
      sample_q <= wco_pkg::sat16(w_q[7]);
    end
  end

  assign f1_sum  = frozen_q ? f1_q : wco_pkg::sat32(33'(f1_q) + 33'(f1_step_q));
  assign f1_next = f1_sum[31] ? 32'sd0 : f1_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      freq_step_q <= '0;
      f1_step_q   <= '0;
      f2_step_q   <= '0;
      f3_step_q   <= '0;
      phase_q     <= '0;
      step_q      <= '0;
      f1_q        <= '0;
      f2_q        <= '0;
      f3_q        <= '0;
      frozen_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wco_pkg::CFG_MODE:       mode_q      <= cfg_data_i[1:0];
          wco_pkg::CFG_FREQ_STEP:  freq_step_q <= cfg_data_i;
          wco_pkg::CFG_FADE1_STEP: f1_step_q   <= cfg_data_i;
          wco_pkg::CFG_FADE2_STEP: f2_step_q   <= cfg_data_i;
          wco_pkg::CFG_FADE3_STEP: f3_step_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.set_value) begin
        unique case (in_sel_i)
          wco_pkg::SET_PHASE: phase_q <= in_value_i;
          wco_pkg::SET_STEP:  step_q  <= in_value_i;
          wco_pkg::SET_FADE1: begin
            f1_q     <= in_value_i;
            frozen_q <= 1'b0;
          end
          wco_pkg::SET_FADE2: f2_q <= in_value_i;
          wco_pkg::SET_FADE3: f3_q <= in_value_i;
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        phase_q <= phase_q + step_q;
        step_q  <= step_q + freq_step_q;
        if (mode_q == 2'd1) begin
          f1_q <= f1_next;
          if (f1_sum[31] || (f1_sum > wco_pkg::FADE_UNITY)) begin
            frozen_q <= 1'b1;
          end
        end else if (mode_q != 2'd0) begin
          f1_q <= wco_pkg::sat32(33'(f1_q) + 33'(f1_step_q));
          f2_q <= wco_pkg::sat32(33'(f2_q) + 33'(f2_step_q));
          if (mode_q == 2'd3) begin
            f3_q <= wco_pkg::sat32(33'(f3_q) + 33'(f3_step_q));
          end
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.mode     = mode_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_sample_o      = sample_q;

endmodule
